### hdl/squared_euclidean_distance_transform_assert.svh
// Assertion macros shared by the distance transform RTL.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef SQUARED_EUCLIDEAN_DISTANCE_TRANSFORM_ASSERT_SVH
`define SQUARED_EUCLIDEAN_DISTANCE_TRANSFORM_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SEDT_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SEDT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

### hdl/sedt_pkg.sv
// ----------------------------------------------------------------------------
// sedt_pkg
// Types and constants of the squared Euclidean distance transform.
// ----------------------------------------------------------------------------
`default_nettype none
package sedt_pkg;
	localparam int MaxWidth  = 256;
	localparam int MaxHeight = 256;
	localparam int CoordW    = 8;
	localparam int AddrW     = 2 * CoordW;
	localparam int DistW     = 18;
	localparam int SizeW     = 9;

	localparam logic [DistW-1:0] DIST_INF = 18'h20000;
	localparam logic [16:0]      DIST_SAT = 17'h1FFFF;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [AddrW-1:0] addr;
		logic [DistW-1:0] wdata;
	} store_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	// One entry of the envelope stack: vertex, its distance, f = dist + v*v,
	// and the left boundary num/den of its parabola.
	typedef struct packed {
		logic        [7:0]  v;
		logic        [16:0] val;
		logic        [17:0] f;
		logic signed [19:0] num;
		logic        [9:0]  den;
	} env_t;
endpackage
`default_nettype wire

### hdl/sedt_ram.sv
// ----------------------------------------------------------------------------
// sedt_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sedt_ram #(
	parameter int W = 18,
	parameter int A = 16
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic         we,
	input  wire logic [A-1:0] addr,
	input  wire logic [W-1:0] wdata,
	output logic      [W-1:0] rdata
);
	logic [W-1:0] mem [2**A];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

### hdl/sedt_engine.sv
// ----------------------------------------------------------------------------
// sedt_engine
// Sequencer of the column and row lower-envelope passes over the store.
// ----------------------------------------------------------------------------
`default_nettype none
module sedt_engine import sedt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SizeW-1:0] width_n,
	input  wire logic [SizeW-1:0] height_n,
	input  wire logic [DistW-1:0] st_rdata,
	output store_req_t            st_req,
	output eng_stat_t             stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_BRD, S_BDAT, S_BMUL, S_BCMP, S_BPOP,
		S_FSTART, S_FLD0, S_FRDN, S_FNX, S_FCMP, S_FSQ, S_FWR, S_FINF, S_NEXT
	} state_t;

	state_t state_q;
	logic row_pass_q, empty_q, done_q;
	logic [7:0] q_q, line_q, top_q, j_q;
	logic [15:0] qsq_q, dq2_q;
	logic [17:0] fq_q, fprod_q;
	logic [16:0] val_q;
	logic signed [19:0] num_q;
	logic [9:0] den_q;
	logic signed [30:0] pa_q, pb_q;
	env_t top_e_q, cur_q;

	logic env_en, env_we;
	logic [7:0] env_addr;
	env_t env_wdata, env_rd;
	logic [$bits(env_t)-1:0] env_rraw;

	logic [7:0] nm1, lines_m1;
	logic [AddrW-1:0] st_addr;
	logic signed [8:0] dq;
	logic [17:0] dsum;
	logic finish;

	assign nm1      = row_pass_q ? 8'(width_n - 9'd1) : 8'(height_n - 9'd1);
	assign lines_m1 = row_pass_q ? 8'(height_n - 9'd1) : 8'(width_n - 9'd1);
	assign st_addr  = row_pass_q ? {line_q, q_q} : {q_q, line_q};
	assign env_rd   = env_t'(env_rraw);
	assign dq       = $signed({1'b0, q_q}) - $signed({1'b0, cur_q.v});
	assign dsum     = {2'b00, dq2_q} + {1'b0, cur_q.val};
	// Last write of the last line of the row pass.
	assign finish   = (state_q == S_FWR || state_q == S_FINF) && q_q == nm1
		&& line_q == lines_m1 && row_pass_q;

	sedt_ram #(.W($bits(env_t)), .A(8)) u_env (
		.clk   (clk),
		.en    (env_en),
		.we    (env_we),
		.addr  (env_addr),
		.wdata (env_wdata),
		.rdata (env_rraw)
	);

	always_comb begin
		env_en    = 1'b0;
		env_we    = 1'b0;
		env_addr  = top_q;
		env_wdata = '{v: q_q, val: val_q, f: fq_q, num: num_q, den: den_q};
		st_req    = '{en: 1'b0, we: 1'b0, addr: st_addr, wdata: DIST_INF};
		case (state_q)
			S_BRD: begin
				st_req.en = 1'b1;
			end
			S_BDAT: begin
				if (!st_rdata[17] && empty_q) begin
					env_en   = 1'b1;
					env_we   = 1'b1;
					env_addr = '0;
					env_wdata = '{v: q_q, val: st_rdata[16:0],
						f: 18'(st_rdata[16:0]) + 18'(qsq_q), num: '0, den: '0};
				end
			end
			S_BCMP: begin
				env_en = 1'b1;
				if (top_q != '0 && pa_q <= pb_q) begin
					env_addr = top_q - 8'd1;
				end else begin
					env_we   = 1'b1;
					env_addr = top_q + 8'd1;
				end
			end
			S_FSTART: begin
				env_en   = !empty_q;
				env_addr = '0;
			end
			S_FRDN: begin
				env_en   = (j_q != top_q);
				env_addr = j_q + 8'd1;
			end
			S_FWR: begin
				st_req.en    = 1'b1;
				st_req.we    = 1'b1;
				st_req.wdata = dsum[17] ? {1'b0, DIST_SAT} : dsum;
			end
			S_FINF: begin
				st_req.en = 1'b1;
				st_req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat = '{busy: (state_q != S_IDLE), done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_pass_q <= 1'b0;
			empty_q    <= 1'b1;
			done_q     <= 1'b0;
			q_q        <= '0;
			line_q     <= '0;
			top_q      <= '0;
			j_q        <= '0;
		end else begin
			done_q <= finish;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						row_pass_q <= 1'b0;
						line_q     <= '0;
						q_q        <= '0;
						empty_q    <= 1'b1;
						state_q    <= S_BRD;
					end
				end
				S_BRD: begin
					qsq_q   <= q_q * q_q;
					state_q <= S_BDAT;
				end
				S_BDAT: begin
					val_q <= st_rdata[16:0];
					fq_q  <= 18'(st_rdata[16:0]) + 18'(qsq_q);
					num_q <= 20'(st_rdata[16:0]) + 20'(qsq_q) - 20'(top_e_q.f);
					den_q <= {1'b0, q_q - top_e_q.v, 1'b0};
					if (st_rdata[17]) begin
						state_q <= S_NEXT;
					end else if (empty_q) begin
						empty_q <= 1'b0;
						top_q   <= '0;
						top_e_q <= '{v: q_q, val: st_rdata[16:0],
							f: 18'(st_rdata[16:0]) + 18'(qsq_q), num: '0, den: '0};
						state_q <= S_NEXT;
					end else begin
						state_q <= S_BMUL;
					end
				end
				S_BMUL: begin
					pa_q    <= 31'(num_q) * 31'($signed({1'b0, top_e_q.den}));
					pb_q    <= 31'(top_e_q.num) * 31'($signed({1'b0, den_q}));
					state_q <= S_BCMP;
				end
				S_BCMP: begin
					if (top_q != '0 && pa_q <= pb_q) begin
						top_q   <= top_q - 8'd1;
						state_q <= S_BPOP;
					end else begin
						top_q   <= top_q + 8'd1;
						top_e_q <= env_wdata;
						state_q <= S_NEXT;
					end
				end
				S_BPOP: begin
					top_e_q <= env_rd;
					num_q   <= 20'(fq_q) - 20'(env_rd.f);
					den_q   <= {1'b0, q_q - env_rd.v, 1'b0};
					state_q <= S_BMUL;
				end
				S_NEXT: begin
					if (q_q == nm1) begin
						q_q     <= '0;
						state_q <= S_FSTART;
					end else begin
						q_q     <= q_q + 8'd1;
						state_q <= S_BRD;
					end
				end
				S_FSTART: begin
					j_q     <= '0;
					state_q <= empty_q ? S_FINF : S_FLD0;
				end
				S_FLD0: begin
					cur_q   <= env_rd;
					state_q <= S_FRDN;
				end
				S_FRDN: begin
					state_q <= (j_q != top_q) ? S_FNX : S_FSQ;
				end
				S_FNX: begin
					fprod_q <= q_q * env_rd.den;
					state_q <= S_FCMP;
				end
				S_FCMP: begin
					if (21'(env_rd.num) < $signed({3'b000, fprod_q})) begin
						j_q     <= j_q + 8'd1;
						cur_q   <= env_rd;
						state_q <= S_FRDN;
					end else begin
						state_q <= S_FSQ;
					end
				end
				S_FSQ: begin
					dq2_q   <= 16'(dq * dq);
					state_q <= S_FWR;
				end
				S_FWR, S_FINF: begin
					if (q_q != nm1) begin
						q_q     <= q_q + 8'd1;
						state_q <= (state_q == S_FWR) ? S_FRDN : S_FINF;
					end else begin
						q_q     <= '0;
						empty_q <= 1'b1;
						if (line_q != lines_m1) begin
							line_q  <= line_q + 8'd1;
							state_q <= S_BRD;
						end else if (!row_pass_q) begin
							row_pass_q <= 1'b1;
							line_q     <= '0;
							state_q    <= S_BRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/squared_euclidean_distance_transform.sv
// ----------------------------------------------------------------------------
// squared_euclidean_distance_transform
// Exact squared Euclidean distance transform over a 256 x 256 pixel store.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  s_*      in         load, transform and read commands
//  m_*      out        transform-finished and read-data results
//  cfg_*    in         image width and height writes
//
// A read result waits for the output register while it is still occupied.
// A transform runs every column, then every row. Per pixel the build reads the
// store, then compares against the envelope top and pops entries until the new
// parabola is pushed; the resolve walks the envelope forward and writes the
// distance, or writes infinity on a line with no finite entry.
// Reset clears control state only; commands stall during a transform and while
// a result waits for the output register.
`default_nettype none
module squared_euclidean_distance_transform import sedt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// s_tdata, from bit 0: pixel_x[7:0], pixel_y[7:0], feature, zero fill.
	input  wire logic [23:0]      s_tdata,
	// s_tuser: operation[1:0].
	input  wire logic [1:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// m_tdata, from bit 0: sq_distance[16:0], no_feature, zero fill.
	output logic [23:0]           m_tdata,
	// m_tuser: result_kind.
	output logic [0:0]            m_tuser,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [SizeW-1:0] cfg_data
);
	typedef enum logic [1:0] {T_IDLE, T_READ, T_RUN, T_FIN} state_t;

	state_t state_q;
	logic [SizeW-1:0] width_q, height_q, width_n, height_n;
	logic m_tvalid_q, kind_q, nf_q;
	logic [16:0] sq_q;

	op_t op;
	logic accept, out_free, out_load;
	logic [7:0] px, py;
	store_req_t top_req, eng_req, st_req;
	eng_stat_t eng_stat;
	logic [DistW-1:0] st_rdata;

	assign op       = op_t'(s_tuser);
	assign px       = s_tdata[7:0];
	assign py       = s_tdata[15:8];
	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	// A new result enters the output register this cycle.
	assign out_load = (state_q == T_READ || state_q == T_FIN) && out_free;

	// Register values of zero act as one; anything above the store acts as full.
	assign width_n  = (width_q == '0) ? SizeW'(1)
		: (width_q > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : width_q;
	assign height_n = (height_q == '0) ? SizeW'(1)
		: (height_q > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : height_q;

	// The command port owns the store except while the engine runs a transform.
	always_comb begin
		top_req.en    = accept && (op == OP_LOAD || op == OP_READ);
		top_req.we    = (op == OP_LOAD);
		top_req.addr  = {py, px};
		top_req.wdata = s_tdata[16] ? '0 : DIST_INF;
	end
	assign st_req = eng_stat.busy ? eng_req : top_req;

	sedt_ram #(.W(DistW), .A(AddrW)) u_store (
		.clk   (clk),
		.en    (st_req.en),
		.we    (st_req.we),
		.addr  (st_req.addr),
		.wdata (st_req.wdata),
		.rdata (st_rdata)
	);

	sedt_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && op == OP_RUN),
		.width_n  (width_n),
		.height_n (height_n),
		.st_rdata (st_rdata),
		.st_req   (eng_req),
		.stat     (eng_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SizeW'(MaxWidth);
			height_q <= SizeW'(MaxHeight);
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// Command sequencing and the output register. Store read data stays held
	// in the RAM output while a read result waits for the output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			m_tvalid_q <= 1'b0;
			kind_q     <= KIND_DONE;
			nf_q       <= 1'b0;
			sq_q       <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept && op == OP_READ) begin
						state_q <= T_READ;
					end else if (accept && op == OP_RUN) begin
						state_q <= T_RUN;
					end
				end
				T_READ: begin
					if (out_free) begin
						kind_q  <= KIND_READ;
						nf_q    <= st_rdata[17];
						sq_q    <= st_rdata[17] ? '0 : st_rdata[16:0];
						state_q <= T_IDLE;
					end
				end
				T_RUN: begin
					if (eng_stat.done) begin
						state_q <= T_FIN;
					end
				end
				T_FIN: begin
					if (out_free) begin
						kind_q  <= KIND_DONE;
						nf_q    <= 1'b0;
						sq_q    <= '0;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, nf_q, sq_q};
	assign m_tuser  = kind_q;

	`include "squared_euclidean_distance_transform_assert.svh"

	// No command is taken while the engine owns the store.
	`SEDT_ASSERT_SAME(a_busy_blocks_input, eng_stat.busy, !s_tready)
	// Completion is only reported while the top level waits on a transform.
	`SEDT_ASSERT_SAME(a_done_in_run, eng_stat.done, state_q == T_RUN)
	// A transform command starts the engine on the next cycle.
	`SEDT_ASSERT_NEXT(a_run_starts, accept && op == OP_RUN, eng_stat.busy)
	// A finished result leaves with a zero payload.
	`SEDT_ASSERT_SAME(a_done_payload, m_tvalid && m_tuser == KIND_DONE, m_tdata == '0)
endmodule
`default_nettype wire
